// ----- rtl/core/srt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  // fixed point format of every data value
  localparam int FRAC_BITS = 8;
  localparam int ONE_FIX = 1 << FRAC_BITS;

  // table contents after reset, before saturation to the data width
  localparam longint THRESH_INIT = 64'sd10240;
  localparam longint SLOPE_INIT = 64'sd256;

  // channel field of an input transaction
  localparam int CHAN_WIDTH = 6;
  localparam int CHAN_SPAN = 1 << CHAN_WIDTH;

  // accumulator width
  localparam int ACC_WIDTH = 32;

  // configuration port
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_FWD  = 2'd1,
    FUNC_BWD  = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_NEG_SLOPE      = 3'd0,
    CFG_THRESH_SHARED  = 3'd1,
    CFG_SLOPE_SHARED   = 3'd2,
    CFG_PROP_TO_PARAMS = 3'd3,
    CFG_PROP_TO_INPUT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/srt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface srt_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [5:0]            chan;
  logic [DATA_WIDTH-1:0] sample;
  logic [DATA_WIDTH-1:0] upstream_grad;
  logic [DATA_WIDTH-1:0] thresh_value;
  logic [DATA_WIDTH-1:0] slope_value;

  modport source (
    output valid, func, chan, sample, upstream_grad, thresh_value, slope_value,
    input  ready
  );

  modport sink (
    input  valid, func, chan, sample, upstream_grad, thresh_value, slope_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/srt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface srt_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] activation;
  logic [DATA_WIDTH-1:0] input_grad;
  logic [31:0]           thresh_grad;
  logic [31:0]           slope_grad;

  modport source (
    output valid, activation, input_grad, thresh_grad, slope_grad,
    input  ready
  );

  modport sink (
    input  valid, activation, input_grad, thresh_grad, slope_grad,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/srt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/shifted_relu_train_unit.sv -----
// sequence by function: load and read pass READ and DONE, forward READ, MUL1 and DONE,
// backward READ, MUL1, MUL2, MUL3 and DONE; the output register is loaded on leaving DONE
// one transaction in flight; a new one is taken only once the sequencer is back in IDLE
// reset is asynchronous, active low; afterwards a clearing pass over every channel writes
// the reset contents into all four tables, input ready stays low meanwhile
// configuration writes are taken in any cycle, also during the clearing pass
`timescale 1ns / 1ps
`default_nettype none

module shifted_relu_train_unit
  import srt_pkg::*;
#(
  parameter int CHANNELS = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  srt_in_if.sink                         in_i,
  srt_out_if.source                      out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  // table address width
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // multiplier operand width: data plus one for differences, at least the 16-bit slope
  localparam int MW = (DATA_WIDTH + 1 > CFG_DATA_WIDTH + 1) ? DATA_WIDTH + 1
                                                            : CFG_DATA_WIDTH + 1;
  localparam int PW = 2 * MW;
  localparam int SW = PW + 1;

  // saturation bounds
  localparam longint DHI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam longint DLO = -DHI - 64'sd1;
  localparam longint AHI = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
  localparam longint ALO = -AHI - 64'sd1;

  // reset table contents, saturated to the data width
  localparam longint THR_RST_L = (THRESH_INIT > DHI) ? DHI : THRESH_INIT;
  localparam longint SLP_RST_L = (SLOPE_INIT > DHI) ? DHI : SLOPE_INIT;
  localparam logic [DATA_WIDTH-1:0] THR_RST = DATA_WIDTH'(THR_RST_L);
  localparam logic [DATA_WIDTH-1:0] SLP_RST = DATA_WIDTH'(SLP_RST_L);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic signed [CFG_DATA_WIDTH-1:0] neg_slope_q;
  logic thr_shared_q, slp_shared_q, prop_params_q, prop_input_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_slope_q   <= '0;
      thr_shared_q  <= 1'b0;
      slp_shared_q  <= 1'b0;
      prop_params_q <= 1'b1;
      prop_input_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEG_SLOPE:      neg_slope_q   <= cfg_wdata_i;
        CFG_THRESH_SHARED:  thr_shared_q  <= cfg_wdata_i[0];
        CFG_SLOPE_SHARED:   slp_shared_q  <= cfg_wdata_i[0];
        CFG_PROP_TO_PARAMS: prop_params_q <= cfg_wdata_i[0];
        CFG_PROP_TO_INPUT:  prop_input_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // channel reduction: constant table of chan modulo CHANNELS
  // ------------------------------------------------------------------
  logic [AW-1:0] chan_map [CHAN_SPAN];

  for (genvar gi = 0; gi < CHAN_SPAN; gi++) begin : g_chan_map
    assign chan_map[gi] = AW'(gi % CHANNELS);
  end

  logic [AW-1:0] chan_idx, ti_d, pi_d;

  assign chan_idx = chan_map[in_i.chan];
  // shared mode points every channel at entry zero
  assign ti_d = thr_shared_q ? '0 : chan_idx;
  assign pi_d = slp_shared_q ? '0 : chan_idx;

  // ------------------------------------------------------------------
  // sequencer state and clearing pass
  // ------------------------------------------------------------------
  state_e state_q, state_d;
  logic clr_busy_q;
  logic [AW-1:0] clr_cnt_q;
  logic in_acc, done_go;

  assign in_i.ready = (state_q == ST_IDLE) && !clr_busy_q;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(CHANNELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // ------------------------------------------------------------------
  // transaction registers, captured at acceptance
  // ------------------------------------------------------------------
  func_e func_q;
  logic [AW-1:0] ti_q, pi_q;
  logic signed [DATA_WIDTH-1:0] x_q, g_q;
  logic [DATA_WIDTH-1:0] tv_q, sv_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(in_i.func);
      ti_q   <= ti_d;
      pi_q   <= pi_d;
      x_q    <= in_i.sample;
      g_q    <= in_i.upstream_grad;
      tv_q   <= in_i.thresh_value;
      sv_q   <= in_i.slope_value;
    end
  end

  // ------------------------------------------------------------------
  // tables: threshold, slope and the two gradient accumulators
  // ------------------------------------------------------------------
  logic thr_we, slp_we, tacc_we, sacc_we;
  logic [AW-1:0] thr_waddr, slp_waddr;
  logic [DATA_WIDTH-1:0] thr_wdata, slp_wdata, thr_rdata, slp_rdata;
  logic [ACC_WIDTH-1:0] tacc_wdata, sacc_wdata, tacc_rdata, sacc_rdata;

  srt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CHANNELS)) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .re_i    (in_acc),
    .raddr_i (ti_d),
    .rdata_o (thr_rdata)
  );

  srt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CHANNELS)) u_slp_ram (
    .clk_i   (clk_i),
    .we_i    (slp_we),
    .waddr_i (slp_waddr),
    .wdata_i (slp_wdata),
    .re_i    (in_acc),
    .raddr_i (pi_d),
    .rdata_o (slp_rdata)
  );

  srt_ram #(.WIDTH(ACC_WIDTH), .DEPTH(CHANNELS)) u_tacc_ram (
    .clk_i   (clk_i),
    .we_i    (tacc_we),
    .waddr_i (thr_waddr),
    .wdata_i (tacc_wdata),
    .re_i    (in_acc),
    .raddr_i (ti_d),
    .rdata_o (tacc_rdata)
  );

  srt_ram #(.WIDTH(ACC_WIDTH), .DEPTH(CHANNELS)) u_sacc_ram (
    .clk_i   (clk_i),
    .we_i    (sacc_we),
    .waddr_i (slp_waddr),
    .wdata_i (sacc_wdata),
    .re_i    (in_acc),
    .raddr_i (pi_d),
    .rdata_o (sacc_rdata)
  );

  // read data holds until the next transaction, so it serves the whole sequence
  logic signed [DATA_WIDTH-1:0] thr_s, slp_s;
  logic x_le0, x_lt_t, acc_en;

  assign thr_s  = $signed(thr_rdata);
  assign slp_s  = $signed(slp_rdata);
  // non-positive sample: sign bit set or all zero
  assign x_le0  = x_q[DATA_WIDTH-1] || (x_q == '0);
  assign x_lt_t = x_q < thr_s;
  // gradient condition x >= t stands on its own, also for non-positive samples
  assign acc_en = prop_params_q && !x_lt_t;

  // ------------------------------------------------------------------
  // shared multiplier, one product per cycle
  // ------------------------------------------------------------------
  logic signed [MW-1:0] mul_a, mul_b, x_m, g_m, t_m, p_m, ns_m, one_m;
  logic signed [PW-1:0] prod_q, shifted;

  assign x_m   = MW'(x_q);
  assign g_m   = MW'(g_q);
  assign t_m   = MW'(thr_s);
  assign p_m   = MW'(slp_s);
  assign ns_m  = MW'(neg_slope_q);
  assign one_m = MW'(ONE_FIX);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_READ: begin
        if (func_q == FUNC_FWD) begin
          // lower piece ns*x, upper piece p*(x - t)
          mul_a = x_le0 ? ns_m : p_m;
          mul_b = x_le0 ? x_m : (x_m - t_m);
        end else begin
          mul_a = x_le0 ? ns_m : p_m;
          mul_b = g_m;
        end
      end
      ST_MUL1: begin
        // threshold gradient g*(1 - p)
        mul_a = g_m;
        mul_b = one_m - p_m;
      end
      ST_MUL2: begin
        // slope gradient g*(x - t)
        mul_a = g_m;
        mul_b = x_m - t_m;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // floor scaling back to the data format
  assign shifted = prod_q >>> FRAC_BITS;

  // ------------------------------------------------------------------
  // data result: forward activation or input gradient
  // ------------------------------------------------------------------
  logic signed [SW-1:0] res_sum;
  logic signed [DATA_WIDTH-1:0] res_sat, res_q;

  always_comb begin
    res_sum = '0;
    if (func_q == FUNC_FWD) begin
      if (x_le0) begin
        res_sum = SW'(shifted);
      end else if (x_lt_t) begin
        res_sum = SW'(x_q);
      end else begin
        res_sum = SW'(thr_s) + SW'(shifted);
      end
    end else if (prop_input_q) begin
      if (x_lt_t && !x_le0) begin
        res_sum = SW'(g_q);
      end else begin
        res_sum = SW'(shifted);
      end
    end
  end

  always_comb begin
    if (res_sum > SW'(DHI)) begin
      res_sat = DATA_WIDTH'(DHI);
    end else if (res_sum < SW'(DLO)) begin
      res_sat = DATA_WIDTH'(DLO);
    end else begin
      res_sat = DATA_WIDTH'(res_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL1) begin
      res_q <= res_sat;
    end
  end

  // ------------------------------------------------------------------
  // accumulator update, one saturating add shared by both gradients
  // ------------------------------------------------------------------
  logic signed [ACC_WIDTH-1:0] acc_base, acc_sat, tacc_q, sacc_q;
  logic signed [SW-1:0] acc_sum;

  assign acc_base = (state_q == ST_MUL2) ? $signed(tacc_rdata) : $signed(sacc_rdata);
  assign acc_sum  = SW'(acc_base) + SW'(shifted);

  always_comb begin
    if (acc_sum > SW'(AHI)) begin
      acc_sat = ACC_WIDTH'(AHI);
    end else if (acc_sum < SW'(ALO)) begin
      acc_sat = ACC_WIDTH'(ALO);
    end else begin
      acc_sat = ACC_WIDTH'(acc_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL2) begin
      tacc_q <= acc_sat;
    end
    if (state_q == ST_MUL3) begin
      sacc_q <= acc_sat;
    end
  end

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  logic out_valid_q;

  assign done_go = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (func_q == FUNC_FWD || func_q == FUNC_BWD) begin
          state_d = ST_MUL1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL1: state_d = (func_q == FUNC_BWD) ? ST_MUL2 : ST_DONE;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_DONE;
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------
  // write-back: clearing pass, parameter load, accumulate, read-and-clear
  // no forwarding needed: writes land before the next transaction reads
  // ------------------------------------------------------------------
  always_comb begin
    thr_waddr  = clr_busy_q ? clr_cnt_q : ti_q;
    slp_waddr  = clr_busy_q ? clr_cnt_q : pi_q;
    thr_wdata  = clr_busy_q ? THR_RST : tv_q;
    slp_wdata  = clr_busy_q ? SLP_RST : sv_q;
    thr_we     = clr_busy_q || (done_go && func_q == FUNC_LOAD);
    slp_we     = thr_we;
    tacc_we    = clr_busy_q ||
                 (done_go && (func_q == FUNC_READ || (func_q == FUNC_BWD && acc_en)));
    sacc_we    = tacc_we;
    tacc_wdata = (clr_busy_q || func_q == FUNC_READ) ? '0 : tacc_q;
    sacc_wdata = (clr_busy_q || func_q == FUNC_READ) ? '0 : sacc_q;
  end

  // ------------------------------------------------------------------
  // output register, parts the result from the next transaction
  // ------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] act_out_q, ig_out_q;
  logic [ACC_WIDTH-1:0]  tg_out_q, sg_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_go) begin
      act_out_q <= (func_q == FUNC_FWD) ? res_q : '0;
      ig_out_q  <= (func_q == FUNC_BWD) ? res_q : '0;
      tg_out_q  <= (func_q == FUNC_READ) ? tacc_rdata : '0;
      sg_out_q  <= (func_q == FUNC_READ) ? sacc_rdata : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.activation  = act_out_q;
  assign out_o.input_grad  = ig_out_q;
  assign out_o.thresh_grad = tg_out_q;
  assign out_o.slope_grad  = sg_out_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // no transaction is taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_i.ready)
    else $error("input transaction accepted during clearing pass");

  // an accepted transaction always goes on to the table read
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_READ))
    else $error("accepted transaction did not start a table read");

  // write-back never collides with the read of a new transaction
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tacc_we || thr_we) |-> !in_acc)
    else $error("table write in the same cycle as a table read");

  // a pending result is never overwritten before it is taken
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !done_go)
    else $error("result register loaded while holding an untaken result");

endmodule

`default_nettype wire

// ----- dv/shifted_relu_train_unit_test.sv -----
`timescale 1ns / 1ps

module shifted_relu_train_unit_test;
  import srt_pkg::*;

  localparam int CHANNELS = 64;
  localparam int DATA_WIDTH = 16;
  // receiver hold-off long enough to back the block up into the sender
  localparam int unsigned HOLD_CYCLES = 300;

  // one input transaction
  typedef struct packed {
    func_e                       func;
    logic [CHAN_WIDTH-1:0]       chan;
    logic signed [DATA_WIDTH-1:0] sample;
    logic signed [DATA_WIDTH-1:0] upstream_grad;
    logic signed [DATA_WIDTH-1:0] thresh_value;
    logic signed [DATA_WIDTH-1:0] slope_value;
  } relu_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] activation;
    logic signed [DATA_WIDTH-1:0] input_grad;
    logic signed [ACC_WIDTH-1:0]  thresh_grad;
    logic signed [ACC_WIDTH-1:0]  slope_grad;
  } relu_result_t;

  // directed row: a fixed result is used where it is obvious by inspection
  typedef struct {
    relu_item_t   item;
    bit           fixed;
    relu_result_t res;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i;

  srt_in_if #(.DATA_WIDTH(DATA_WIDTH)) in_bus ();
  srt_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_bus ();

  shifted_relu_train_unit #(
    .CHANNELS  (CHANNELS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow copy of the block's tables and accumulators
  logic signed [DATA_WIDTH-1:0] thresh_tab[CHANNELS];
  logic signed [DATA_WIDTH-1:0] slope_tab[CHANNELS];
  logic signed [ACC_WIDTH-1:0]  thresh_acc[CHANNELS];
  logic signed [ACC_WIDTH-1:0]  slope_acc[CHANNELS];

  // shadow copy of the configuration registers
  logic signed [DATA_WIDTH-1:0] neg_slope;
  bit thr_shared;
  bit slp_shared;
  bit prop_params;
  bit prop_input;

  relu_result_t pending_results[$];
  stim_row_t    stim_table[$];
  int           mismatch_count;

  // steady: neither side idles; hold_req: ask the receiver for a long hold-off
  bit          steady;
  bit          hold_req;
  int unsigned hold_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on the run time
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // q8.8 product, floor toward minus infinity
  function automatic longint fixmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // expected result of one accepted transaction, updates the shadow state
  function automatic relu_result_t predict_relu(relu_item_t it);
    relu_result_t res;
    int unsigned  ti;
    int unsigned  si;
    longint       x;
    longint       g;
    longint       t;
    longint       p;
    longint       act;
    longint       ig;
    res = '0;
    ti = thr_shared ? 0 : it.chan;
    si = slp_shared ? 0 : it.chan;
    x = it.sample;
    g = it.upstream_grad;
    t = thresh_tab[ti];
    p = slope_tab[si];
    case (it.func)
      FUNC_LOAD: begin
        thresh_tab[ti] = it.thresh_value;
        slope_tab[si] = it.slope_value;
      end
      FUNC_FWD: begin
        if (x <= 0) act = fixmul(neg_slope, x);
        else if (x < t) act = x;
        else act = t + fixmul(p, x - t);
        res.activation = DATA_WIDTH'(clamp_to(act, DATA_WIDTH));
      end
      FUNC_BWD: begin
        // the gradient condition is tested on its own, non-positive samples included
        if (prop_params && x >= t) begin
          thresh_acc[ti] = ACC_WIDTH'(clamp_to(thresh_acc[ti] + fixmul(g, ONE_FIX - p),
                                               ACC_WIDTH));
          slope_acc[si] = ACC_WIDTH'(clamp_to(slope_acc[si] + fixmul(g, x - t), ACC_WIDTH));
        end
        if (prop_input) begin
          if (x <= 0) ig = fixmul(neg_slope, g);
          else if (x < t) ig = g;
          else ig = fixmul(p, g);
          res.input_grad = DATA_WIDTH'(clamp_to(ig, DATA_WIDTH));
        end
      end
      FUNC_READ: begin
        res.thresh_grad = thresh_acc[ti];
        res.slope_grad = slope_acc[si];
        thresh_acc[ti] = '0;
        slope_acc[si] = '0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    // quiet after the first hundred
    if (mismatch_count <= 100) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // q8.8 value, leaning toward the extremes and the values around zero
  function automatic logic signed [DATA_WIDTH-1:0] pick_q88();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $urandom_range(1) ? 16'sh0000 : 16'shffff;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // random transaction, channels bunched so accumulators build up between reads
  function automatic relu_item_t random_item();
    relu_item_t  it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) it.func = FUNC_LOAD;
    else if (pick < 50) it.func = FUNC_FWD;
    else if (pick < 85) it.func = FUNC_BWD;
    else it.func = FUNC_READ;
    it.chan = ($urandom_range(9) < 6) ? CHAN_WIDTH'($urandom_range(3)) : CHAN_WIDTH'($urandom);
    it.sample = pick_q88();
    it.upstream_grad = pick_q88();
    it.thresh_value = pick_q88();
    it.slope_value = pick_q88();
    return it;
  endfunction

  task automatic add_row(func_e f, int ch, int x, int g, int tv, int sv,
                         bit fixed, int act, int ig, int tg, int sg);
    stim_row_t row;
    row.item.func = f;
    row.item.chan = CHAN_WIDTH'(ch);
    row.item.sample = DATA_WIDTH'(x);
    row.item.upstream_grad = DATA_WIDTH'(g);
    row.item.thresh_value = DATA_WIDTH'(tv);
    row.item.slope_value = DATA_WIDTH'(sv);
    row.fixed = fixed;
    row.res.activation = DATA_WIDTH'(act);
    row.res.input_grad = DATA_WIDTH'(ig);
    row.res.thresh_grad = ACC_WIDTH'(tg);
    row.res.slope_grad = ACC_WIDTH'(sg);
    stim_table.push_back(row);
  endtask

  // offer one transaction, maybe after a short gap; returns at the accepting edge
  task automatic drive_item(relu_item_t it, bit fixed, relu_result_t fixed_res);
    relu_result_t res;
    if (!steady && $urandom_range(99) < 24) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= it.func;
    in_bus.chan <= it.chan;
    in_bus.sample <= it.sample;
    in_bus.upstream_grad <= it.upstream_grad;
    in_bus.thresh_value <= it.thresh_value;
    in_bus.slope_value <= it.slope_value;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    // the shadow state advances on every transaction, fixed rows too
    res = predict_relu(it);
    pending_results.push_back(fixed ? fixed_res : res);
  endtask

  // stop offering and wait until every result is in, then let the block drain before returning
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // write all five registers back to back, only while the block is idle
  task automatic apply_settings(logic signed [DATA_WIDTH-1:0] ns, bit ts, bit ss,
                                bit pp, bit pin);
    write_reg(CFG_NEG_SLOPE, ns);
    write_reg(CFG_THRESH_SHARED, CFG_DATA_WIDTH'(ts));
    write_reg(CFG_SLOPE_SHARED, CFG_DATA_WIDTH'(ss));
    write_reg(CFG_PROP_TO_PARAMS, CFG_DATA_WIDTH'(pp));
    write_reg(CFG_PROP_TO_INPUT, CFG_DATA_WIDTH'(pin));
    cfg_we_i <= 1'b0;
    neg_slope = ns;
    thr_shared = ts;
    slp_shared = ss;
    prop_params = pp;
    prop_input = pin;
  endtask

  // one phase of random traffic under one setting
  task automatic run_phase(logic signed [DATA_WIDTH-1:0] ns, bit ts, bit ss, bit pp, bit pin,
                           int n);
    apply_settings(ns, ts, ss, pp, pin);
    repeat (n) drive_item(random_item(), 1'b0, '0);
    settle();
  endtask

  // receiver: random idling, always ready in steady mode, and one long hold-off on request
  initial begin
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // result checker: compare every accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    relu_result_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("activation", $signed(out_bus.activation), want.activation);
        check_field("input_grad", $signed(out_bus.input_grad), want.input_grad);
        check_field("thresh_grad", $signed(out_bus.thresh_grad), want.thresh_grad);
        check_field("slope_grad", $signed(out_bus.slope_grad), want.slope_grad);
      end
    end
  end

  initial begin : stimulus
    relu_item_t it;
    int         k;

    mismatch_count = 0;
    steady = 1'b0;
    hold_req = 1'b0;

    // shadow state as after reset
    for (k = 0; k < CHANNELS; k++) begin
      thresh_tab[k] = DATA_WIDTH'(THRESH_INIT);
      slope_tab[k] = DATA_WIDTH'(SLOPE_INIT);
      thresh_acc[k] = '0;
      slope_acc[k] = '0;
    end
    neg_slope = '0;
    thr_shared = 1'b0;
    slp_shared = 1'b0;
    prop_params = 1'b1;
    prop_input = 1'b1;

    // every input known from time zero, reset asserted from time zero as well, then released
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    in_bus.valid <= 1'b0;
    in_bus.func <= FUNC_LOAD;
    in_bus.chan <= '0;
    in_bus.sample <= '0;
    in_bus.upstream_grad <= '0;
    in_bus.thresh_value <= '0;
    in_bus.slope_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table under reset settings: threshold 40.0, slope 1.0, negative slope 0
    //       func       ch  sample  grad    thresh  slope  fixed act     ig      tg sg
    add_row(FUNC_READ,  0,  0,      0,      0,      0,     1,    0,      0,      0, 0);
    // non-positive samples with a zero negative slope
    add_row(FUNC_FWD,   0,  0,      0,      0,      0,     1,    0,      0,      0, 0);
    add_row(FUNC_FWD,   0,  -32768, 0,      0,      0,     1,    0,      0,      0, 0);
    // linear middle range and the upper extreme
    add_row(FUNC_FWD,   0,  1,      0,      0,      0,     1,    1,      0,      0, 0);
    add_row(FUNC_FWD,   0,  32767,  0,      0,      0,     1,    32767,  0,      0, 0);
    // sample exactly at the threshold
    add_row(FUNC_FWD,   63, 10240,  0,      0,      0,     1,    10240,  0,      0, 0);
    // backward below the threshold passes the gradient, a zero sample gets none, above it the sums build up
    add_row(FUNC_BWD,   1,  100,    -32768, 0,      0,     1,    0,      -32768, 0, 0);
    add_row(FUNC_BWD,   1,  0,      1234,   0,      0,     1,    0,      0,      0, 0);
    add_row(FUNC_BWD,   2,  32767,  32767,  0,      0,     1,    0,      32767,  0, 0);
    add_row(FUNC_READ,  2,  0,      0,      0,      0,     0,    0,      0,      0, 0);
    // a second read finds the accumulators cleared
    add_row(FUNC_READ,  2,  0,      0,      0,      0,     1,    0,      0,      0, 0);
    // most negative threshold and slope
    add_row(FUNC_LOAD,  3,  0,      0,      -32768, -32768, 1,   0,      0,      0, 0);
    add_row(FUNC_FWD,   3,  32767,  0,      0,      0,     1,    -32768, 0,      0, 0);
    add_row(FUNC_FWD,   3,  -32768, 0,      0,      0,     1,    0,      0,      0, 0);
    // gradient condition met by non-positive samples
    add_row(FUNC_BWD,   3,  -100,   1000,   0,      0,     0,    0,      0,      0, 0);
    add_row(FUNC_BWD,   3,  -32768, -32768, 0,      0,     0,    0,      0,      0, 0);
    add_row(FUNC_READ,  3,  0,      0,      0,      0,     0,    0,      0,      0, 0);
    // most positive threshold and slope
    add_row(FUNC_LOAD,  4,  0,      0,      32767,  32767, 1,    0,      0,      0, 0);
    add_row(FUNC_FWD,   4,  32767,  0,      0,      0,     1,    32767,  0,      0, 0);
    add_row(FUNC_BWD,   4,  32767,  32767,  0,      0,     1,    0,      32767,  0, 0);
    add_row(FUNC_BWD,   4,  32767,  -32768, 0,      0,     1,    0,      -32768, 0, 0);
    add_row(FUNC_READ,  4,  0,      0,      0,      0,     0,    0,      0,      0, 0);
    // mixed bit pattern on the top channel
    add_row(FUNC_LOAD,  63, 0,      0,      255,    23130, 1,    0,      0,      0, 0);
    add_row(FUNC_FWD,   63, 256,    0,      0,      0,     0,    0,      0,      0, 0);
    add_row(FUNC_READ,  63, 0,      0,      0,      0,     1,    0,      0,      0, 0);

    foreach (stim_table[i]) drive_item(stim_table[i].item, stim_table[i].fixed,
                                       stim_table[i].res);
    settle();

    // random phases over the register settings, extremes included
    run_phase(16'sh0000, 1'b0, 1'b0, 1'b1, 1'b1, 230);
    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    run_phase(16'sh8000, 1'b1, 1'b0, 1'b1, 1'b1, 230);
    run_phase(16'sh7fff, 1'b0, 1'b1, 1'b0, 1'b1, 230);
    run_phase(DATA_WIDTH'($urandom), 1'b1, 1'b1, 1'b1, 1'b0, 230);
    run_phase(16'sh0080, 1'b0, 1'b0, 1'b0, 1'b0, 230);

    // accumulator saturation, both directions, with no idling on either side
    apply_settings(16'shff00, 1'b0, 1'b0, 1'b1, 1'b1);
    steady = 1'b1;
    for (k = 0; k < 2; k++) begin
      it.func = FUNC_LOAD;
      it.chan = CHAN_WIDTH'(5 + k);
      it.sample = '0;
      it.upstream_grad = '0;
      it.thresh_value = 16'sh8000;
      it.slope_value = 16'sh8000;
      drive_item(it, 1'b0, '0);
      it.func = FUNC_BWD;
      repeat (300) begin
        it.sample = {8'h7f, 8'($urandom)};
        // positive gradients drive the sums up, negative ones down
        it.upstream_grad = (k == 0) ? {8'h7f, 8'($urandom)} : {8'h80, 8'($urandom)};
        it.thresh_value = DATA_WIDTH'($urandom);
        it.slope_value = DATA_WIDTH'($urandom);
        drive_item(it, 1'b0, '0);
      end
      it.func = FUNC_READ;
      drive_item(it, 1'b0, '0);
    end
    settle();
    steady = 1'b0;

    run_phase(DATA_WIDTH'($urandom), 1'b0, 1'b0, 1'b1, 1'b1, 230);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
